@@ design/ttem_pkg.sv @@
// timer table expiry manager package: action and status codes, sequencer states
// and fixed widths of the timer fields. no dependencies.
package ttem_pkg;

  localparam int ID_W      = 16;
  localparam int TIME_W    = 48;
  localparam int ACT_W     = 2;
  localparam int STATUS_W  = 3;
  localparam int IN_DATA_W = 112;  // id + expiry + current time, whole bytes
  localparam int MAX_RESULTS = 16;
  localparam int EXP_CNT_W   = 5;  // holds MAX_RESULTS

  localparam logic [ACT_W-1:0] ACT_SET    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CANCEL = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TICK   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT,
    S_NEXT
  } seq_state_t;

endpackage

@@ design/timer_table_expiry_manager.sv @@
// timer table expiry manager: table of pending timers scanned by one compare unit
// under a small sequencer. depends on ttem_pkg.
//
//   channel | dir | tdata                                        | tuser       | tlast
//   in_     | in  | timer_id[15:0] expiry[63:16] cur_time[111:64] | action[1:0] | -
//   out_    | out | result_id[15:0]                              | status[2:0] | last
//
// set and cancel make one table pass at one entry a cycle through the registered
// id/expiry memory read port, then load the result word into the output register.
// a tick makes one table pass per expired timer, plus a closing pass below
// MAX_RESULTS expiries; each expired timer adds a restart step and a load.
// in_tready is high only in the idle state; a stalled output holds the sequencer.
// reset empties the table at once through the valid flops, no clearing pass.
module timer_table_expiry_manager #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ttem_pkg::IN_DATA_W-1:0]  in_tdata,   // timer_id, expiry_time, current_time
  input  logic [ttem_pkg::ACT_W-1:0]      in_tuser,   // action
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ttem_pkg::ID_W-1:0]       out_tdata,  // result_id
  output logic [ttem_pkg::STATUS_W-1:0]   out_tuser,  // status
  output logic                            out_tlast
);
  import ttem_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // id and expiry store, one read and one write port
  logic [ID_W-1:0]   mem_id  [TABLE_ENTRIES];
  logic [TIME_W-1:0] mem_exp [TABLE_ENTRIES];

  seq_state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [ACT_W-1:0]         op_r, op_nxt;
  logic [ID_W-1:0]          id_r, id_nxt;
  logic [TIME_W-1:0]        tm_r, tm_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;

  logic [CNT_W-1:0] issue_r, issue_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [ID_W-1:0]   rd_id_r;
  logic [TIME_W-1:0] rd_exp_r;

  logic              hit_r, hit_nxt;
  logic [IDX_W-1:0]  hit_idx_r, hit_idx_nxt;
  logic              free_r, free_nxt;
  logic [IDX_W-1:0]  free_idx_r, free_idx_nxt;
  logic              best_r, best_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [ID_W-1:0]   best_id_r, best_id_nxt;
  logic [TIME_W-1:0] best_exp_r, best_exp_nxt;

  logic                 pend_r, pend_nxt;
  logic [ID_W-1:0]      pend_id_r, pend_id_nxt;
  logic [EXP_CNT_W-1:0] cnt_r, cnt_nxt;

  logic [STATUS_W-1:0] emit_st_r, emit_st_nxt;
  logic [ID_W-1:0]     emit_id_r, emit_id_nxt;
  logic                emit_last_r, emit_last_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_st_r, out_st_nxt;
  logic [ID_W-1:0]     out_id_r, out_id_nxt;
  logic                out_last_r, out_last_nxt;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic              cur_valid;
  logic              is_due;
  logic              is_better;
  logic              scan_done;
  logic              out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_id_r;
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;

  assign cur_valid = valid_r[cmp_idx_r];
  assign is_due    = (rd_exp_r <= tm_r);
  assign is_better = !best_r || (rd_exp_r < best_exp_r) ||
                     ((rd_exp_r == best_exp_r) && (rd_id_r < best_id_r));
  assign scan_done = (issue_r == CNT_W'(TABLE_ENTRIES)) && !rd_pend_r;
  assign out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_id_r  <= mem_id[rd_addr];
      rd_exp_r <= mem_exp[rd_addr];
    end
    if (wr_en) begin
      mem_id[wr_idx]  <= id_r;
      mem_exp[wr_idx] <= tm_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    tm_nxt        = tm_r;
    valid_nxt     = valid_r;
    issue_nxt     = issue_r;
    rd_pend_nxt   = rd_pend_r;
    cmp_idx_nxt   = cmp_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    best_nxt      = best_r;
    best_idx_nxt  = best_idx_r;
    best_id_nxt   = best_id_r;
    best_exp_nxt  = best_exp_r;
    pend_nxt      = pend_r;
    pend_id_nxt   = pend_id_r;
    cnt_nxt       = cnt_r;
    emit_st_nxt   = emit_st_r;
    emit_id_nxt   = emit_id_r;
    emit_last_nxt = emit_last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_st_nxt    = out_st_r;
    out_id_nxt    = out_id_r;
    out_last_nxt  = out_last_r;
    rd_en         = 1'b0;
    rd_addr       = issue_r[IDX_W-1:0];
    wr_en         = 1'b0;
    wr_idx        = hit_idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt      = in_tuser;
          id_nxt      = in_tdata[ID_W-1:0];
          // one time register: expiry for set, current time for tick
          tm_nxt      = (in_tuser == ACT_TICK) ? in_tdata[ID_W+2*TIME_W-1:ID_W+TIME_W]
                                               : in_tdata[ID_W+TIME_W-1:ID_W];
          issue_nxt   = '0;
          rd_pend_nxt = 1'b0;
          hit_nxt     = 1'b0;
          free_nxt    = 1'b0;
          best_nxt    = 1'b0;
          pend_nxt    = 1'b0;
          cnt_nxt     = '0;
          if (in_tuser inside {ACT_SET, ACT_CANCEL, ACT_TICK}) begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (issue_r != CNT_W'(TABLE_ENTRIES)) begin
          rd_en       = 1'b1;
          issue_nxt   = issue_r + 1'b1;
          rd_pend_nxt = 1'b1;
          cmp_idx_nxt = issue_r[IDX_W-1:0];
        end else begin
          rd_pend_nxt = 1'b0;
        end

        if (rd_pend_r) begin
          if (cur_valid && rd_id_r == id_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = cmp_idx_r;
          end
          if (!cur_valid && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = cmp_idx_r;
          end
          if (cur_valid && is_due && is_better) begin
            best_nxt     = 1'b1;
            best_idx_nxt = cmp_idx_r;
            best_id_nxt  = rd_id_r;
            best_exp_nxt = rd_exp_r;
          end
        end

        if (scan_done) begin
          emit_id_nxt   = id_r;
          emit_last_nxt = 1'b1;
          ret_nxt       = S_IDLE;
          case (op_r)
            ACT_SET: begin
              state_nxt = S_EMIT;
              if (hit_r) begin
                wr_en       = 1'b1;
                wr_idx      = hit_idx_r;
                emit_st_nxt = ST_UPDATED;
              end else if (free_r) begin
                wr_en             = 1'b1;
                wr_idx            = free_idx_r;
                valid_nxt[free_idx_r] = 1'b1;
                emit_st_nxt       = ST_INSERTED;
              end else begin
                emit_st_nxt = ST_FULL;
              end
            end
            ACT_CANCEL: begin
              state_nxt = S_EMIT;
              if (hit_r) begin
                valid_nxt[hit_idx_r] = 1'b0;
                emit_st_nxt          = ST_CANCELLED;
              end else begin
                emit_st_nxt = ST_NOTFOUND;
              end
            end
            default: begin
              // tick: the earliest due timer is held back one pass so that
              // its last flag is known before it goes out
              emit_st_nxt = ST_EXPIRED;
              emit_id_nxt = pend_id_r;
              if (best_r) begin
                valid_nxt[best_idx_r] = 1'b0;
                pend_nxt      = 1'b1;
                pend_id_nxt   = best_id_r;
                cnt_nxt       = cnt_r + 1'b1;
                emit_last_nxt = 1'b0;
                ret_nxt       = S_NEXT;
                state_nxt     = pend_r ? S_EMIT : S_NEXT;
              end else begin
                state_nxt = pend_r ? S_EMIT : S_IDLE;
              end
            end
          endcase
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = emit_st_r;
          out_id_nxt    = emit_id_r;
          out_last_nxt  = emit_last_r;
          state_nxt     = ret_r;
        end
      end

      S_NEXT: begin
        if (cnt_r == EXP_CNT_W'(MAX_RESULTS)) begin
          emit_st_nxt   = ST_EXPIRED;
          emit_id_nxt   = pend_id_r;
          emit_last_nxt = 1'b1;
          ret_nxt       = S_IDLE;
          state_nxt     = S_EMIT;
        end else begin
          issue_nxt   = '0;
          rd_pend_nxt = 1'b0;
          best_nxt    = 1'b0;
          state_nxt   = S_SCAN;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      valid_r     <= '0;
      rd_pend_r   <= 1'b0;
      issue_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      best_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      valid_r     <= valid_nxt;
      rd_pend_r   <= rd_pend_nxt;
      issue_r     <= issue_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      best_r      <= best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    id_r        <= id_nxt;
    tm_r        <= tm_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    hit_idx_r   <= hit_idx_nxt;
    free_idx_r  <= free_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_id_r   <= best_id_nxt;
    best_exp_r  <= best_exp_nxt;
    pend_id_r   <= pend_id_nxt;
    emit_st_r   <= emit_st_nxt;
    emit_id_r   <= emit_id_nxt;
    emit_last_r <= emit_last_nxt;
    out_st_r    <= out_st_nxt;
    out_id_r    <= out_id_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule
